// File: rtl/nubf_pkg.sv
// Shared types and constants for the NAL unit boundary finder.
// No dependencies; imported by every module of the block.
`default_nettype none
package nubf_pkg;

    // Result status codes
    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_NOSTART  = 2'd2;

    // H.264 unit types
    localparam logic [5:0] H264_IDR  = 6'd5;
    localparam logic [5:0] H264_SPS  = 6'd7;
    localparam logic [5:0] H264_PPS  = 6'd8;
    localparam logic [5:0] H264_VCL_LO = 6'd1;

    // HEVC unit types
    localparam logic [5:0] HEVC_IDR_W_RADL = 6'd19;
    localparam logic [5:0] HEVC_IDR_N_LP   = 6'd20;
    localparam logic [5:0] HEVC_SPS        = 6'd33;
    localparam logic [5:0] HEVC_PPS        = 6'd34;
    localparam logic [5:0] HEVC_VCL_HI     = 6'd31;

    // Output word layout (tdata), lowest bit first
    localparam int TDATA_W  = 112;
    localparam int TUSER_W  = 2;
    localparam int BIT_TYPE = 96;
    localparam int BIT_SPS  = 102;
    localparam int BIT_PPS  = 103;
    localparam int BIT_IDR  = 104;
    localparam int BIT_VCL  = 105;

    // Ended unit as the scanner reports it, before classification
    typedef struct packed {
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic [31:0] length;
        logic [5:0]  unit_type;
        logic        type_ok;
        logic [1:0]  status;
    } t_scan_res;

    // Complete result word
    typedef struct packed {
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic [31:0] length;
        logic [5:0]  unit_type;
        logic        flag_sps;
        logic        flag_pps;
        logic        flag_idr;
        logic        flag_vcl;
        logic [1:0]  status;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/nubf_scan.sv
// Start code scanner: byte history, offsets and open-unit state.
// Depends on nubf_pkg (t_scan_res, status codes).
`default_nettype none
module nubf_scan #(
    parameter int OFFSET_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire  [7:0]            i_byte,
    input  wire                   i_last,
    input  wire                   i_hevc,
    output logic                  o_res_valid,
    output nubf_pkg::t_scan_res   o_res
);
    import nubf_pkg::*;

    logic [23:0]            r_hist;
    logic [1:0]             r_cnt;
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_inside;
    logic [OFFSET_BITS-1:0] r_start;
    logic                   r_hdr;
    logic [5:0]             r_type;
    logic                   r_any;

    logic [23:0]            n_hist;
    logic [1:0]             n_cnt;
    logic                   n_inside;
    logic [OFFSET_BITS-1:0] n_start;
    logic                   n_hdr;
    logic [5:0]             n_type;
    logic                   n_any;

    logic                   full;
    logic [5:0]             hdr_type;
    logic [5:0]             type_eff;
    logic                   hdr_eff;
    logic                   term;
    logic                   in_mid;
    logic                   start;
    logic [OFFSET_BITS-1:0] pos_p1;

    logic [OFFSET_BITS-1:0] emit_start;
    logic [OFFSET_BITS-1:0] emit_end;
    logic [OFFSET_BITS-1:0] emit_len;
    logic [5:0]             emit_type;
    logic                   emit_hdr;
    logic [1:0]             emit_status;
    logic                   emit_zero;
    logic [OFFSET_BITS+31:0] ext_start;
    logic [OFFSET_BITS+31:0] ext_end;
    logic [OFFSET_BITS+31:0] ext_len;

    always_comb begin
        n_hist   = {r_hist[15:0], i_byte};
        n_cnt    = (r_cnt == 2'd3) ? 2'd3 : r_cnt + 2'd1;
        full     = (r_cnt >= 2'd2);
        hdr_type = i_hevc ? i_byte[6:1] : {1'b0, i_byte[4:0]};
        type_eff = (r_inside && !r_hdr) ? hdr_type : r_type;
        hdr_eff  = r_hdr || r_inside;
        term     = r_inside && full && (n_hist <= 24'd1);
        in_mid   = r_inside && !term;
        start    = !in_mid && full && (n_hist == 24'd1);
        pos_p1   = r_pos + 1'b1;

        n_inside = in_mid || start;
        n_start  = start ? pos_p1 : r_start;
        n_hdr    = start ? 1'b0 : hdr_eff;
        n_type   = start ? 6'd0 : type_eff;
        n_any    = r_any || start;

        // Pick the unit to report: a start code or 00 00 00 closes the open unit,
        // the last byte closes whatever is still open or reports a stream without start.
        o_res_valid = 1'b0;
        emit_start  = r_start;
        emit_end    = r_pos - OFFSET_BITS'(2);
        emit_type   = type_eff;
        emit_hdr    = 1'b1;
        emit_status = ST_COMPLETE;
        emit_zero   = 1'b0;
        if (term) begin
            o_res_valid = 1'b1;
        end else if (i_last && n_inside) begin
            o_res_valid = 1'b1;
            emit_start  = n_start;
            emit_end    = pos_p1;
            emit_type   = n_type;
            emit_hdr    = n_hdr;
            emit_status = ST_TRUNC;
        end else if (i_last && !n_any) begin
            o_res_valid = 1'b1;
            emit_status = ST_NOSTART;
            emit_zero   = 1'b1;
        end
        emit_len  = emit_end - emit_start;
        ext_start = {32'd0, emit_start};
        ext_end   = {32'd0, emit_end};
        ext_len   = {32'd0, emit_len};

        o_res.start_off = emit_zero ? 32'd0 : ext_start[31:0];
        o_res.end_off   = emit_zero ? 32'd0 : ext_end[31:0];
        o_res.length    = emit_zero ? 32'd0 : ext_len[31:0];
        o_res.unit_type = emit_type;
        o_res.type_ok   = !emit_zero && emit_hdr && (emit_len != '0);
        o_res.status    = emit_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_hist   <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_inside <= 1'b0;
            r_start  <= '0;
            r_hdr    <= 1'b0;
            r_type   <= '0;
            r_any    <= 1'b0;
        end else if (i_accept) begin
            r_hist   <= n_hist;
            r_cnt    <= n_cnt;
            r_pos    <= pos_p1;
            r_inside <= n_inside;
            r_start  <= n_start;
            r_hdr    <= n_hdr;
            r_type   <= n_type;
            r_any    <= n_any;
        end
    end

endmodule
`default_nettype wire

// File: rtl/nubf_classify.sv
// Unit type classification (SPS, PPS, IDR, VCL) for H.264 and HEVC.
// Depends on nubf_pkg (t_scan_res, t_result, type constants).
`default_nettype none
module nubf_classify (
    input  wire                  i_hevc,
    input  nubf_pkg::t_scan_res  i_res,
    output nubf_pkg::t_result    o_res
);
    import nubf_pkg::*;

    logic [5:0] t;

    always_comb begin
        t = i_res.unit_type;
        o_res.start_off = i_res.start_off;
        o_res.end_off   = i_res.end_off;
        o_res.length    = i_res.length;
        o_res.status    = i_res.status;
        o_res.unit_type = '0;
        o_res.flag_sps  = 1'b0;
        o_res.flag_pps  = 1'b0;
        o_res.flag_idr  = 1'b0;
        o_res.flag_vcl  = 1'b0;
        // Empty or headerless units carry no type
        if (i_res.type_ok) begin
            o_res.unit_type = t;
            if (i_hevc) begin
                o_res.flag_sps = (t == HEVC_SPS);
                o_res.flag_pps = (t == HEVC_PPS);
                o_res.flag_idr = (t == HEVC_IDR_W_RADL) || (t == HEVC_IDR_N_LP);
                o_res.flag_vcl = (t <= HEVC_VCL_HI);
            end else begin
                o_res.flag_sps = (t == H264_SPS);
                o_res.flag_pps = (t == H264_PPS);
                o_res.flag_idr = (t == H264_IDR);
                o_res.flag_vcl = (t >= H264_VCL_LO) && (t <= H264_IDR);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/nal_unit_boundary_finder.sv
// Top level of the Annex B NAL unit boundary finder.
// Depends on nubf_pkg, nubf_scan and nubf_classify.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] data_byte, tlast last_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: unit fields, tuser[1:0] status
//  cfg       in   i_cfg_wen (no handshake)     i_cfg_wdata codec_select
//
//  One byte is taken per clock while s_axis_tready is high; a result, when a
//  byte causes one, shows on m_axis from the output register or via the skid.
//  The scanner's history, offset and unit registers are the only state in the byte
//  path, so throughput is one byte per cycle for as long as m_axis drains.
//  A two-word result buffer (output register plus skid) lets s_axis keep
//  flowing while one result waits; s_axis_tready drops only when both hold words.
//  Reset is synchronous, active low, and clears the scanner, buffer and codec_select.
`default_nettype none
module nal_unit_boundary_finder #(
    parameter int OFFSET_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // codec_select: 0 H.264, 1 HEVC
    input  wire                          i_cfg_wen,
    input  wire                          i_cfg_wdata,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [7:0]                   s_axis_tdata,  // [7:0] data_byte
    input  wire                          s_axis_tlast,  // last_byte
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [31:0] unit_start_offset, [63:32] unit_end_offset, [95:64] unit_length,
    // [101:96] unit_type, [102] flag_sps, [103] flag_pps, [104] flag_idr,
    // [105] flag_vcl, [111:106] zero
    output logic [nubf_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [nubf_pkg::TUSER_W-1:0] m_axis_tuser   // [1:0] status
);
    import nubf_pkg::*;

    logic       r_codec;
    logic       accept;
    logic       pop;
    logic       scan_valid;
    t_scan_res  scan_res;
    t_result    cls_res;

    // Output register and skid stage
    logic       r_out_valid;
    t_result    r_out;
    logic       r_skid_valid;
    t_result    r_skid;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec <= 1'b0;
        end else if (i_cfg_wen) begin
            r_codec <= i_cfg_wdata;
        end
    end

    nubf_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_hevc      (r_codec),
        .o_res_valid (scan_valid),
        .o_res       (scan_res)
    );

    nubf_classify u_classify (
        .i_hevc (r_codec),
        .i_res  (scan_res),
        .o_res  (cls_res)
    );

    // Buffer control: drain the skid first, otherwise load the fresh result
    // into the output register when it is free, else park it in the skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= accept && scan_valid;
        end else if (accept && scan_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || pop) begin
            r_out <= cls_res;
        end else begin
            r_skid <= cls_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.flag_vcl, r_out.flag_idr, r_out.flag_pps,
                            r_out.flag_sps, r_out.unit_type, r_out.length,
                            r_out.end_off, r_out.start_off};
    assign m_axis_tuser  = r_out.status;

endmodule
`default_nettype wire

// File: rtl/nubf_checker.sv
// Port-level checks for the NAL unit boundary finder, bound to the top level.
// Depends on nubf_pkg (status codes, output word layout).
`default_nettype none
module nubf_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [nubf_pkg::TDATA_W-1:0]  m_axis_tdata,
    input wire [nubf_pkg::TUSER_W-1:0]  m_axis_tuser
);
    import nubf_pkg::*;

    // Hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_COMPLETE) || (m_axis_tuser == ST_TRUNC)
                          || (m_axis_tuser == ST_NOSTART))
        else $error("undefined status code");

    a_nostart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NOSTART) |-> (m_axis_tdata == '0))
        else $error("no-start result carries nonzero fields");

    a_flag_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[BIT_IDR] |->
            m_axis_tdata[BIT_VCL] && !m_axis_tdata[BIT_SPS] && !m_axis_tdata[BIT_PPS])
        else $error("IDR unit not classified as VCL only");

endmodule

bind nal_unit_boundary_finder nubf_checker u_nubf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: test/nal_unit_boundary_finder_test.sv
// Self-checking testbench for nal_unit_boundary_finder: Annex B byte streams in,
// unit boundary reports out, checked against a scan model kept in this file.
// Depends on nubf_pkg and the nal_unit_boundary_finder RTL only.
`default_nettype none
module nal_unit_boundary_finder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nubf_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RST_CYCLES  = 12;
    localparam int HOLD_CYCLES = 120;     // long receiver hold-off
    localparam int SETTLE      = 4;       // cycles after the last report before idle
    localparam int CYCLE_LIMIT = 300000;

    typedef enum logic [0:0] {
        RX_FREE,    // ready but for a hold-off
        RX_CHOPPY   // random short stalls
    } rx_mode_e;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wen;
    logic                i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [7:0] data_byte
    logic                s_axis_tlast;   // last_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [31:0] start, [63:32] end, [95:64] length, [101:96] type, [102] sps,
    // [103] pps, [104] idr, [105] vcl, [111:106] zero
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [TUSER_W-1:0]  m_axis_tuser;   // [1:0] status

    nal_unit_boundary_finder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scan model state: a private copy of the block's history and unit state
    // ------------------------------------------------------------------
    logic [23:0] hist;
    logic [1:0]  hist_cnt;
    logic [31:0] byte_pos;
    bit          in_unit;
    logic [31:0] cur_start;
    bit          hdr_seen;
    logic [5:0]  cur_type;
    bit          seen_start;
    bit          codec_hevc;

    t_result     pending_units[$];   // unit reports still owed by the DUT

    // Run bookkeeping
    int          fail_cnt;
    int          bytes_taken;
    int          words_sent;
    int          status_cnt[4];
    int          cycle_cnt;

    // Stimulus control
    logic [7:0]  stream_bytes[$];
    bit          tx_gaps = 1'b1;
    int          burst_left;
    rx_mode_e    rx_mode;
    int          hold_asks;

    // Drop back to the state of a fresh stream
    function automatic void restart_stream();
        hist       = '0;
        hist_cnt   = '0;
        byte_pos   = '0;
        in_unit    = 1'b0;
        cur_start  = '0;
        hdr_seen   = 1'b0;
        cur_type   = '0;
        seen_start = 1'b0;
    endfunction

    // Build the report for the open unit ending at end_off. A unit without
    // header or with zero length carries no type and no flags.
    function automatic t_result close_unit(logic [31:0] end_off, logic [1:0] st);
        t_result r;
        r           = '0;
        r.start_off = cur_start;
        r.end_off   = end_off;
        r.length    = end_off - cur_start;
        r.status    = st;
        if (hdr_seen && r.length != 0) begin
            r.unit_type = cur_type;
            if (codec_hevc) begin
                r.flag_sps = (cur_type == HEVC_SPS);
                r.flag_pps = (cur_type == HEVC_PPS);
                r.flag_idr = (cur_type == HEVC_IDR_W_RADL) || (cur_type == HEVC_IDR_N_LP);
                r.flag_vcl = (cur_type <= HEVC_VCL_HI);
            end else begin
                r.flag_sps = (cur_type == H264_SPS);
                r.flag_pps = (cur_type == H264_PPS);
                r.flag_idr = (cur_type == H264_IDR);
                r.flag_vcl = (cur_type >= H264_VCL_LO) && (cur_type <= H264_IDR);
            end
        end
        return r;
    endfunction

    // Advance the scan model by one accepted byte; queue any report it causes
    function automatic void scan_byte(logic [7:0] b, logic last);
        logic [31:0] at;
        bit          ended;
        t_result     r;
        at    = byte_pos;
        ended = 1'b0;
        hist  = {hist[15:0], b};
        if (hist_cnt < 2'd3)
            hist_cnt++;

        if (in_unit) begin
            // First byte of a unit is its header
            if (!hdr_seen) begin
                cur_type = codec_hevc ? b[6:1] : {1'b0, b[4:0]};
                hdr_seen = 1'b1;
            end
            // 00 00 00 or 00 00 01 closes the unit where the pattern began
            if (hist_cnt == 2'd3 && hist <= 24'h000001) begin
                pending_units.push_back(close_unit(at - 32'd2, ST_COMPLETE));
                ended   = 1'b1;
                in_unit = 1'b0;
            end
        end

        if (!in_unit && hist_cnt == 2'd3 && hist == 24'h000001) begin
            in_unit    = 1'b1;
            cur_start  = at + 32'd1;
            hdr_seen   = 1'b0;
            cur_type   = '0;
            seen_start = 1'b1;
        end

        if (last) begin
            if (!ended) begin
                if (in_unit) begin
                    pending_units.push_back(close_unit(at + 32'd1, ST_TRUNC));
                end else if (!seen_start) begin
                    r        = '0;
                    r.status = ST_NOSTART;
                    pending_units.push_back(r);
                end
            end
            restart_stream();
        end else begin
            byte_pos = at + 32'd1;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: track config writes, feed accepted bytes to the model and
    // compare every accepted report with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (!i_rst_n) begin
            restart_stream();
            codec_hevc = 1'b0;
        end else begin
            if (i_cfg_wen)
                codec_hevc = i_cfg_wdata;

            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_units.size() == 0) begin
                    $error("unit report with none expected: tdata 0x%0h tuser %0d",
                           m_axis_tdata, m_axis_tuser);
                    fail_cnt++;
                end else begin
                    want = pending_units.pop_front();
                    check_field("unit_start_offset", want.start_off, m_axis_tdata[31:0]);
                    check_field("unit_end_offset", want.end_off, m_axis_tdata[63:32]);
                    check_field("unit_length", want.length, m_axis_tdata[95:64]);
                    check_field("unit_type", want.unit_type,
                                m_axis_tdata[BIT_TYPE +: 6]);
                    check_field("flag_sps", want.flag_sps, m_axis_tdata[BIT_SPS]);
                    check_field("flag_pps", want.flag_pps, m_axis_tdata[BIT_PPS]);
                    check_field("flag_idr", want.flag_idr, m_axis_tdata[BIT_IDR]);
                    check_field("flag_vcl", want.flag_vcl, m_axis_tdata[BIT_VCL]);
                    check_field("status", want.status, m_axis_tuser);
                    status_cnt[want.status]++;
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                scan_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready by default, random short stalls in choppy mode, and a
    // long hold-off whenever a test bumps hold_asks
    // ------------------------------------------------------------------
    int hold_seen;
    int stall_left;

    always @(posedge i_clk) begin : receiver
        if (hold_seen != hold_asks) begin
            hold_seen  = hold_asks;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && rx_mode == RX_CHOPPY
                     && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 7);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one word and hold it until taken. With gaps on, the sender runs
    // in bursts of random length and idles between them.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_gaps && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Send the staged stream, marking its final byte as the last one
    task automatic send_stream();
        foreach (stream_bytes[k])
            send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    // Drop valid, let the scoreboard take the final byte, drain every owed
    // report, then let the pipe settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_units.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write codec_select; only called while idle
    task automatic set_codec(input bit hevc);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= hevc;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // H.264 corner cases: four-byte start code, IDR slice, empty unit,
    // 00 00 00 end followed by a trailing last byte, stream without any
    // start code, and a start code that completes on the last byte.
    task automatic test_h264_directed();
        wait_idle();
        set_codec(1'b0);
        stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h00,
                         8'h01, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00,
                         8'hFF};
        send_stream();
        stream_bytes = '{8'h3A, 8'hC5};
        send_stream();
        stream_bytes = '{8'h00, 8'h00, 8'h01};
        send_stream();
    endtask

    // HEVC classification: SPS, PPS, both IDR types; the stream ends on a
    // start code that also closes the last unit
    task automatic test_hevc_directed();
        wait_idle();
        set_codec(1'b1);
        stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h42, 8'h00, 8'h00, 8'h01, 8'h44,
                         8'h00, 8'h00, 8'h01, 8'h26, 8'h00, 8'h00, 8'h01, 8'h28,
                         8'h00, 8'h00, 8'h01};
        send_stream();
    endtask

    // Mostly well-formed streams of several units with random headers and
    // payloads, mixed with noise rich in 00 and 01 bytes
    task automatic test_random_streams(input bit hevc, input int n_words,
                                       input rx_mode_e mode, input bit gaps);
        int          stop_at;
        int          n_units;
        logic [5:0]  t;
        logic [7:0]  hdr;
        wait_idle();
        set_codec(hevc);
        rx_mode <= mode;
        tx_gaps = gaps;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(0, 2))
                    stream_bytes.push_back(8'($urandom_range(1, 255)));
                n_units = $urandom_range(1, 5);
                repeat (n_units) begin
                    if ($urandom_range(0, 3) == 0)
                        stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h01);
                    // Favor the classified types, allow any
                    case ($urandom_range(0, 4))
                        0:       t = hevc ? HEVC_SPS : H264_SPS;
                        1:       t = hevc ? HEVC_PPS : H264_PPS;
                        2:       t = hevc ? HEVC_IDR_W_RADL : H264_IDR;
                        3:       t = hevc ? HEVC_IDR_N_LP : H264_VCL_LO;
                        default: t = 6'($urandom_range(0, 63));
                    endcase
                    hdr = 8'($urandom_range(0, 255));
                    if (hevc)
                        hdr[6:1] = t;
                    else
                        hdr[4:0] = t[4:0];
                    stream_bytes.push_back(hdr);
                    repeat ($urandom_range(0, 10))
                        stream_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'h00
                                               : 8'($urandom_range(1, 255)));
                end
                // Choose how the stream ends
                case ($urandom_range(0, 3))
                    0: ;  // mid-unit: truncated
                    1: begin
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(8'h00);
                    end
                    2: begin
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(8'h01);
                    end
                    default: begin
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(8'h00);
                        stream_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end else begin
                repeat ($urandom_range(1, 12))
                    stream_bytes.push_back(($urandom_range(0, 2) == 0) ? 8'h00
                                           : ($urandom_range(0, 3) == 0) ? 8'h01
                                           : 8'($urandom_range(0, 255)));
            end
            send_stream();
        end
    endtask

    // Hold the receiver off for a long stretch while back-to-back short
    // units keep arriving, so the result buffer fills and input stalls
    task automatic test_backpressure();
        wait_idle();
        rx_mode <= RX_FREE;
        tx_gaps = 1'b0;
        hold_asks <= hold_asks + 1;
        repeat (12) begin
            stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h00);
            stream_bytes.push_back(8'h01);
            stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
        stream_bytes.push_back(8'hFF);
        send_stream();
        tx_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        rx_mode       = RX_CHOPPY;
        hold_asks     = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_h264_directed();
        test_hevc_directed();
        test_random_streams(1'b1, 300, RX_CHOPPY, 1'b1);
        test_backpressure();
        test_random_streams(1'b0, 300, RX_CHOPPY, 1'b1);
        test_random_streams(1'b1, 300, RX_FREE, 1'b0);
        test_random_streams(1'b0, 300, RX_CHOPPY, 1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);

        if (pending_units.size() != 0) begin
            $error("unit reports never delivered: expected %0d, got 0",
                   pending_units.size());
            fail_cnt++;
        end

        $display("Scanned %0d bytes into %0d unit reports (%0d complete, %0d truncated, %0d no start).",
                 bytes_taken, status_cnt[ST_COMPLETE] + status_cnt[ST_TRUNC]
                 + status_cnt[ST_NOSTART], status_cnt[ST_COMPLETE],
                 status_cnt[ST_TRUNC], status_cnt[ST_NOSTART]);
        $display("Both codec settings, bursty and steady input, choppy output and a long hold-off.");
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
